FILE: rtl/calendar_date_add_days_core_macros.svh
// assertion macros for the calendar date adder
// used by the datapath module; no other dependencies
`ifndef CALENDAR_DATE_ADD_DAYS_CORE_MACROS_SVH
`define CALENDAR_DATE_ADD_DAYS_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CDAD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdad assertion failed");
// next-cycle implication
`define CDAD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdad assertion failed");
`else
`define CDAD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CDAD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/cdad_pkg.sv
// shared types, constants and helpers for the calendar date adder
// no dependencies
package cdad_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned COUNT_W = 16;
   // internal year carries one more bit so stepping past 16383 stays exact
   localparam int unsigned YACC_W  = YEAR_W + 1;
   localparam int unsigned OFF_W   = 9;
   localparam int unsigned R25_W   = 5;
   localparam int unsigned Q_W     = 11;
   localparam int unsigned RECIP_W = 16;
   localparam int unsigned PROD_W  = YACC_W + RECIP_W;
   localparam int unsigned RECIP_SHIFT = 20;

   // ceil(2^20 / 25): exact quotient for any 15-bit year
   localparam logic [RECIP_W-1:0] RECIP25 = 16'd41944;
   localparam logic [R25_W-1:0]   MOD25_LAST = 5'd24;
   localparam logic [R25_W-1:0]   MOD25_N    = 5'd25;

   localparam logic [OFF_W-1:0]   YEAR_LEN_LEAP = 9'd366;
   localparam logic [OFF_W-1:0]   YEAR_LEN_NORM = 9'd365;
   localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
   localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
   localparam logic [DAY_W-1:0]   FEB_LEAP      = 5'd29;
   localparam logic [DAY_W-1:0]   FEB_NORM      = 5'd28;

   // datapath operations
   localparam int unsigned OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
   localparam logic [OP_W-1:0] OP_DIV   = 4'd2;
   localparam logic [OP_W-1:0] OP_MOD   = 4'd3;
   localparam logic [OP_W-1:0] OP_CLAMP = 4'd4;
   localparam logic [OP_W-1:0] OP_OFFS  = 4'd5;
   localparam logic [OP_W-1:0] OP_FIRST = 4'd6;
   localparam logic [OP_W-1:0] OP_YEAR  = 4'd7;
   localparam logic [OP_W-1:0] OP_CONV  = 4'd8;
   localparam logic [OP_W-1:0] OP_OUT   = 4'd9;

   typedef struct packed {
      logic [DAY_W-1:0]   start_day;
      logic [MONTH_W-1:0] start_month;
      logic [YEAR_W-1:0]  start_year;
      logic [COUNT_W-1:0] days_to_add;
   } req_type;

   typedef struct packed {
      logic [DAY_W-1:0]   result_day;
      logic [MONTH_W-1:0] result_month;
      logic [YEAR_W-1:0]  result_year;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic offs_done;
      logic first_fits;
      logic year_done;
      logic conv_done;
      logic out_free;
   } stat_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:                   len = leap ? FEB_LEAP : FEB_NORM;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/cdad_ctrl.sv
// sequencer for the calendar date adder: walks the datapath through its phases
// depends on cdad_pkg
module cdad_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cdad_pkg::stat_type stat,
   output cdad_pkg::cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIV   = 4'd1;
   localparam logic [3:0] ST_MOD   = 4'd2;
   localparam logic [3:0] ST_CLAMP = 4'd3;
   localparam logic [3:0] ST_OFFS  = 4'd4;
   localparam logic [3:0] ST_FIRST = 4'd5;
   localparam logic [3:0] ST_YEAR  = 4'd6;
   localparam logic [3:0] ST_CONV  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = cdad_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = cdad_pkg::OP_LOAD;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op   = cdad_pkg::OP_DIV;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.op   = cdad_pkg::OP_MOD;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.op   = cdad_pkg::OP_CLAMP;
            state_in = ST_OFFS;
         end
         ST_OFFS: begin
            cmd.op = cdad_pkg::OP_OFFS;
            if (stat.offs_done) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            cmd.op   = cdad_pkg::OP_FIRST;
            state_in = stat.first_fits ? ST_CONV : ST_YEAR;
         end
         ST_YEAR: begin
            cmd.op = cdad_pkg::OP_YEAR;
            if (stat.year_done) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.op = cdad_pkg::OP_CONV;
            if (stat.conv_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the result register to drain
            if (stat.out_free) begin
               cmd.op   = cdad_pkg::OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/cdad_dp.sv
// datapath of the calendar date adder: date registers, leap logic, step unit
// and result register; depends on cdad_pkg and the assertion macro header
`include "calendar_date_add_days_core_macros.svh"

module cdad_dp (
   input  logic               clock,
   input  logic               reset,
   input  cdad_pkg::cmd_type  cmd,
   output cdad_pkg::stat_type stat,
   input  cdad_pkg::req_type  req_data,
   output cdad_pkg::rsp_type  rsp_data,
   output logic               rsp_valid,
   input  logic               rsp_ready
);

   logic [cdad_pkg::DAY_W-1:0]   day_ff,   day_in;
   logic [cdad_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [cdad_pkg::YACC_W-1:0]  year_ff,  year_in;
   logic [cdad_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [cdad_pkg::Q_W-1:0]     q_ff,     q_in;
   logic [cdad_pkg::R25_W-1:0]   r25_ff,   r25_in;
   logic [cdad_pkg::OFF_W-1:0]   off_ff,   off_in;
   logic [cdad_pkg::MONTH_W-1:0] idx_ff,   idx_in;
   cdad_pkg::rsp_type            rsp_ff,   rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic                         leap;
   logic [cdad_pkg::OFF_W-1:0]   ylen;
   logic [cdad_pkg::OFF_W-1:0]   rem;
   logic [cdad_pkg::DAY_W-1:0]   mlen_start;
   logic [cdad_pkg::DAY_W-1:0]   mlen_idx;
   logic [cdad_pkg::PROD_W-1:0]  prod;
   logic [cdad_pkg::YACC_W-1:0]  q_times25;
   logic [cdad_pkg::YACC_W-1:0]  r_full;
   logic [cdad_pkg::R25_W-1:0]   r25_next;
   logic [cdad_pkg::MONTH_W-1:0] month_clamped;
   logic [cdad_pkg::DAY_W-1:0]   day_clamped;

   // leap: divisible by 4 but not by 25, or divisible by 16 and by 25
   assign leap = ((year_ff[1:0] == 2'b00) && (r25_ff != '0)) ||
                 ((year_ff[3:0] == 4'b0000) && (r25_ff == '0));
   assign ylen = leap ? cdad_pkg::YEAR_LEN_LEAP : cdad_pkg::YEAR_LEN_NORM;
   assign rem  = ylen - off_ff;

   assign mlen_start = cdad_pkg::month_len(month_ff, leap);
   assign mlen_idx   = cdad_pkg::month_len(idx_ff, leap);

   // year / 25 by reciprocal multiply, remainder on the following cycle
   assign prod = {{cdad_pkg::RECIP_W{1'b0}}, year_ff} *
                 {{cdad_pkg::YACC_W{1'b0}}, cdad_pkg::RECIP25};
   assign q_times25 = ({4'b0, q_ff} << 4) + ({4'b0, q_ff} << 3) + {4'b0, q_ff};
   assign r_full    = year_ff - q_times25;
   assign r25_next  = (r25_ff == cdad_pkg::MOD25_LAST) ? '0 : r25_ff + 5'd1;

   always_comb begin
      month_clamped = req_data.start_month;
      if (req_data.start_month == '0) begin
         month_clamped = cdad_pkg::MONTH_FIRST;
      end else if (req_data.start_month > cdad_pkg::MONTH_LAST) begin
         month_clamped = cdad_pkg::MONTH_LAST;
      end
   end

   always_comb begin
      day_clamped = day_ff;
      if (day_ff == '0) begin
         day_clamped = 5'd1;
      end else if (day_ff > mlen_start) begin
         day_clamped = mlen_start;
      end
   end

   assign stat.offs_done  = (idx_ff >= month_ff);
   assign stat.first_fits = (count_ff <= {7'b0, rem});
   assign stat.year_done  = (count_ff <= {7'b0, ylen});
   assign stat.conv_done  = (idx_ff >= cdad_pkg::MONTH_LAST) ||
                            (off_ff <= {4'b0, mlen_idx});
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      count_in     = count_ff;
      q_in         = q_ff;
      r25_in       = r25_ff;
      off_in       = off_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (cmd.op)
         cdad_pkg::OP_LOAD: begin
            day_in   = req_data.start_day;
            month_in = month_clamped;
            year_in  = {1'b0, req_data.start_year};
            count_in = req_data.days_to_add;
         end
         cdad_pkg::OP_DIV: begin
            q_in = prod[cdad_pkg::RECIP_SHIFT +: cdad_pkg::Q_W];
         end
         cdad_pkg::OP_MOD: begin
            r25_in = r_full[cdad_pkg::R25_W-1:0];
         end
         cdad_pkg::OP_CLAMP: begin
            off_in = {4'b0, day_clamped};
            idx_in = cdad_pkg::MONTH_FIRST;
         end
         cdad_pkg::OP_OFFS: begin
            if (!stat.offs_done) begin
               off_in = off_ff + {4'b0, mlen_idx};
               idx_in = idx_ff + 4'd1;
            end
         end
         cdad_pkg::OP_FIRST: begin
            if (stat.first_fits) begin
               off_in = off_ff + count_ff[cdad_pkg::OFF_W-1:0];
               idx_in = cdad_pkg::MONTH_FIRST;
            end else begin
               count_in = count_ff - {7'b0, rem};
               year_in  = year_ff + 15'd1;
               r25_in   = r25_next;
            end
         end
         cdad_pkg::OP_YEAR: begin
            if (!stat.year_done) begin
               count_in = count_ff - {7'b0, ylen};
               year_in  = year_ff + 15'd1;
               r25_in   = r25_next;
            end else begin
               off_in = count_ff[cdad_pkg::OFF_W-1:0];
               idx_in = cdad_pkg::MONTH_FIRST;
            end
         end
         cdad_pkg::OP_CONV: begin
            if (!stat.conv_done) begin
               off_in = off_ff - {4'b0, mlen_idx};
               idx_in = idx_ff + 4'd1;
            end
         end
         cdad_pkg::OP_OUT: begin
            rsp_in.result_day   = off_ff[cdad_pkg::DAY_W-1:0];
            rsp_in.result_month = idx_ff;
            rsp_in.result_year  = year_ff[cdad_pkg::YEAR_W-1:0];
            rsp_valid_in        = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      count_ff <= count_in;
      q_ff     <= q_in;
      r25_ff   <= r25_in;
      off_ff   <= off_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   `CDAD_ASSERT_IMP(a_conv_idx_range, clock, reset, cmd.op == cdad_pkg::OP_CONV, idx_ff >= cdad_pkg::MONTH_FIRST && idx_ff <= cdad_pkg::MONTH_LAST)
   `CDAD_ASSERT_IMP(a_conv_off_range, clock, reset, cmd.op == cdad_pkg::OP_CONV, off_ff != '0 && off_ff <= cdad_pkg::YEAR_LEN_LEAP)
   `CDAD_ASSERT_IMP(a_r25_range, clock, reset, cmd.op == cdad_pkg::OP_YEAR || cmd.op == cdad_pkg::OP_CONV, r25_ff < cdad_pkg::MOD25_N)
   `CDAD_ASSERT_NXT(a_year_step, clock, reset, cmd.op == cdad_pkg::OP_YEAR && !stat.year_done, year_ff == $past(year_ff) + 15'd1)
   `CDAD_ASSERT_NXT(a_out_load, clock, reset, cmd.op == cdad_pkg::OP_OUT, rsp_valid_ff)

endmodule

FILE: rtl/calendar_date_add_days_core.sv
// Gregorian date plus day count: takes a start date and a count of days and
// returns the date that many days later, one result per item. After acceptance
// an item passes the divide, remainder and clamp steps, one offset step per
// month before the start month, the first-year check, one subtract per further
// whole year crossed and one step per month of the result, then waits while an
// earlier result still sits in the output register; the year subtract loop in
// the datapath takes one year per cycle. A month of 0 or above 12 is taken as
// 1 or 12, a day of 0 or past the month end is clamped into the month, and
// result_year keeps the low 14 bits of the full year. The result sits in an
// output register, so the next item is taken while it waits.
// depends on cdad_pkg, cdad_ctrl and cdad_dp
module calendar_date_add_days_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdad_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdad_pkg::rsp_type rsp_data
);

   cdad_pkg::cmd_type  cmd;
   cdad_pkg::stat_type stat;

   cdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cdad_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

FILE: sim/tb_calendar_date_add_days_core.sv
// self-checking bench for calendar_date_add_days_core: directed and random dates
// are pushed through the valid/ready ports and each result is checked in order
// depends on cdad_pkg and the calendar_date_add_days_core rtl
module tb_calendar_date_add_days_core;

   localparam int CLK_HALF     = 4;
   localparam int RANDOM_ITEMS = 1350;
   localparam int TAIL_ITEMS   = 100;
   localparam int SETTLE_CYCLES = 250;
   localparam int LIMIT_CYCLES = 1500000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   cdad_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   cdad_pkg::rsp_type rsp_data;

   cdad_pkg::req_type dates_to_send[$];
   cdad_pkg::rsp_type dates_due[$];
   logic    req_took = 1'b0;
   logic    quiet = 1'b0;
   int      send_gap = 0;
   int      hold_left = 0;
   int      dates_checked = 0;
   int      mismatches = 0;
   int      directed_count = 0;

   calendar_date_add_days_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned year_days(int unsigned y);
      return is_leap(y) ? int'(cdad_pkg::YEAR_LEN_LEAP) : int'(cdad_pkg::YEAR_LEN_NORM);
   endfunction

   function automatic int unsigned days_in_month(int unsigned m, bit leap);
      case (m)
         2:           return leap ? int'(cdad_pkg::FEB_LEAP) : int'(cdad_pkg::FEB_NORM);
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // full-width date math, truncated to the port widths at the end
   function automatic cdad_pkg::rsp_type date_after_days(cdad_pkg::req_type q);
      int unsigned       d, m, y, x, off, rem, y2, ml;
      bit                leap;
      cdad_pkg::rsp_type r;
      d = q.start_day;
      m = q.start_month;
      y = q.start_year;
      x = q.days_to_add;
      leap = is_leap(y);
      if (m < cdad_pkg::MONTH_FIRST) m = cdad_pkg::MONTH_FIRST;
      if (m > cdad_pkg::MONTH_LAST) m = cdad_pkg::MONTH_LAST;
      ml = days_in_month(m, leap);
      if (d < 1) d = 1;
      if (d > ml) d = ml;
      off = d;
      for (int unsigned i = 1; i < m; i++) off += days_in_month(i, leap);
      rem = year_days(y) - off;
      if (x <= rem) begin
         y2 = y;
         off += x;
      end else begin
         x -= rem;
         y2 = y + 1;
         // stop once the remainder fits in the year, so 31 december stays day 366/365
         while (x > year_days(y2)) begin
            x -= year_days(y2);
            y2++;
         end
         off = x;
      end
      leap = is_leap(y2);
      m = cdad_pkg::MONTH_FIRST;
      while (m < cdad_pkg::MONTH_LAST && off > days_in_month(m, leap)) begin
         off -= days_in_month(m, leap);
         m++;
      end
      r.result_day   = off[cdad_pkg::DAY_W-1:0];
      r.result_month = m[cdad_pkg::MONTH_W-1:0];
      r.result_year  = y2[cdad_pkg::YEAR_W-1:0];
      return r;
   endfunction

   function automatic cdad_pkg::req_type make_date(int unsigned d, int unsigned m,
                                                   int unsigned y, int unsigned x);
      cdad_pkg::req_type q;
      q.start_day   = d[cdad_pkg::DAY_W-1:0];
      q.start_month = m[cdad_pkg::MONTH_W-1:0];
      q.start_year  = y[cdad_pkg::YEAR_W-1:0];
      q.days_to_add = x[cdad_pkg::COUNT_W-1:0];
      return q;
   endfunction

   // driver: holds an item until it is taken, with random gaps between items before the tail
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (dates_to_send.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= dates_to_send.pop_front();
            if (dates_to_send.size() < TAIL_ITEMS) begin
               quiet <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
               send_gap <= $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         hold_left <= $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: check each result against the oldest prediction
   always @(posedge clock) begin
      cdad_pkg::rsp_type want;
      req_took <= req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (dates_due.size() == 0) begin
            $error("result with no item pending: %0d/%0d/%0d", rsp_data.result_day,
                   rsp_data.result_month, rsp_data.result_year);
            mismatches++;
         end else begin
            want = dates_due.pop_front();
            if (rsp_data.result_day !== want.result_day) begin
               $error("result_day: expected %0d, got %0d", want.result_day,
                      rsp_data.result_day);
               mismatches++;
            end
            if (rsp_data.result_month !== want.result_month) begin
               $error("result_month: expected %0d, got %0d", want.result_month,
                      rsp_data.result_month);
               mismatches++;
            end
            if (rsp_data.result_year !== want.result_year) begin
               $error("result_year: expected %0d, got %0d", want.result_year,
                      rsp_data.result_year);
               mismatches++;
            end
            dates_checked++;
         end
      end
      if (!reset && req_valid && req_ready) dates_due.push_back(date_after_days(req_data));
   end

   initial begin
      int unsigned y, m, d, x;
      // directed corners
      dates_to_send.push_back(make_date(1, 1, 1, 0));
      dates_to_send.push_back(make_date(31, 12, 9999, 0));
      dates_to_send.push_back(make_date(31, 12, 2023, 1));
      dates_to_send.push_back(make_date(28, 2, 2024, 1));
      dates_to_send.push_back(make_date(28, 2, 2023, 1));
      dates_to_send.push_back(make_date(28, 2, 1900, 1));
      dates_to_send.push_back(make_date(28, 2, 2000, 1));
      dates_to_send.push_back(make_date(31, 12, 2022, 365));
      dates_to_send.push_back(make_date(1, 1, 2023, 364));
      dates_to_send.push_back(make_date(1, 1, 2024, 365));
      dates_to_send.push_back(make_date(31, 12, 2099, 60));
      dates_to_send.push_back(make_date(29, 2, 2024, 1461));
      dates_to_send.push_back(make_date(15, 0, 2021, 10));
      dates_to_send.push_back(make_date(20, 13, 2021, 15));
      dates_to_send.push_back(make_date(31, 15, 1999, 1));
      dates_to_send.push_back(make_date(0, 3, 2010, 5));
      dates_to_send.push_back(make_date(31, 2, 2024, 0));
      dates_to_send.push_back(make_date(30, 2, 2023, 0));
      dates_to_send.push_back(make_date(31, 4, 2015, 0));
      dates_to_send.push_back(make_date(1, 3, 0, 100));
      dates_to_send.push_back(make_date(31, 15, 16383, 65535));
      dates_to_send.push_back(make_date(31, 12, 9999, 65535));
      dates_to_send.push_back(make_date(1, 1, 1, 65535));
      dates_to_send.push_back(make_date(0, 0, 0, 0));
      directed_count = dates_to_send.size();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 4) == 0) begin
            // raw fields: out-of-range months, days and years past 9999
            dates_to_send.push_back(make_date($urandom, $urandom, $urandom, $urandom));
         end else begin
            y = $urandom_range(1, 9999);
            m = $urandom_range(1, 12);
            d = $urandom_range(1, days_in_month(m, is_leap(y)));
            case ($urandom_range(0, 3))
               0:       x = $urandom_range(0, 800);
               1:       x = year_days(y) - 1 + $urandom_range(0, 2);
               default: x = $urandom_range(0, 65535);
            endcase
            dates_to_send.push_back(make_date(d, m, y, x));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (dates_to_send.size() > 0 || req_valid || dates_due.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d dates (%0d directed corners, rest random incl. raw fields)",
               dates_checked, directed_count);
      $display("covered leap rules, clamped day/month, year zero and 14-bit year wrap");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * CLK_HALF);
      $display("timeout with %0d results outstanding", dates_due.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
